// File: design/gwrap_pkg.sv
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Character codes, field widths and the result types shared by the wrap block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwrap_pkg;

  localparam int unsigned FieldBits = 16;

  localparam logic [7:0] CharEnd   = 8'd0;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;

  localparam logic [FieldBits-1:0] FieldMax   = 16'hFFFF;
  localparam logic [FieldBits-1:0] WidthReset = 16'd80;

  typedef struct packed {
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] length;
    logic [FieldBits-1:0] widest;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic two;
    res_t first;
    res_t second;
  } push_t;

endpackage

`default_nettype wire

// File: design/greedy_word_wrap_spans.sv
// ----------------------------------------------------------------------------
// Greedy word wrap spans
// Splits a byte stream into greedily wrapped lines and reports each line span.
// ----------------------------------------------------------------------------
// One character is taken per cycle unless the input stalls. Each character is
// registered, then judged; its lines go through the output register. Most
// characters yield no line or one line; if one closes two, the second waits in
// the pending slot and holds the next line-yielding character until it moves
// into the single output register. The user must write the line width through
// the configuration port while no text is in flight; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap_spans #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gwrap_pkg::FieldBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      char_code_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gwrap_pkg::FieldBits-1:0] line_start_o,
  output logic [gwrap_pkg::FieldBits-1:0] line_length_o,
  output logic [gwrap_pkg::FieldBits-1:0] widest_line_o,
  output logic                            last_of_run_o
);
  import gwrap_pkg::*;

  logic [FieldBits-1:0] line_width_q;
  logic                 in_valid_q;
  logic [7:0]           char_q;
  logic                 fire;
  logic                 ok;
  push_t                push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= WidthReset;
      in_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        line_width_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_code_i;
    end
  end

  gwrap_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(in_valid_q),
    .char_i      (char_q),
    .line_width_i(line_width_q),
    .ok_i        (ok),
    .fire_o      (fire),
    .push_o      (push)
  );

  gwrap_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .ok_o         (ok),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_start_o (line_start_o),
    .line_length_o(line_length_o),
    .widest_line_o(widest_line_o),
    .last_of_run_o(last_of_run_o)
  );

`ifndef SYNTH
  a_stall_only_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  a_fire_needs_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> in_valid_q)
    else $error("character judged without a registered character");

  a_push_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> fire)
    else $error("lines pushed without a judged character");
`endif

endmodule

`default_nettype wire

// File: design/gwrap_core.sv
// ----------------------------------------------------------------------------
// Greedy word wrap core
// Holds the text state and judges one character per cycle while the output
// buffer has room, producing up to two line spans for the output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwrap_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           char_valid_i,
  input  logic [7:0]                     char_i,
  input  logic [gwrap_pkg::FieldBits-1:0] line_width_i,
  input  logic                           ok_i,
  output logic                           fire_o,
  output gwrap_pkg::push_t               push_o
);
  import gwrap_pkg::*;

  localparam int unsigned C        = COUNT_BITS;
  localparam int unsigned CmpBits  = (C + 2 > FieldBits) ? C + 2 : FieldBits;
  localparam int unsigned WideBits = (C > FieldBits) ? C : FieldBits;
  localparam logic [C-1:0] CountMax = '1;

  function automatic logic [FieldBits-1:0] clip(input logic [C-1:0] x);
    logic [WideBits-1:0] v;
    v = WideBits'(x);
    return (v > WideBits'(FieldMax)) ? FieldMax : v[FieldBits-1:0];
  endfunction

  function automatic logic [C-1:0] sat_inc(input logic [C-1:0] x);
    return (x == CountMax) ? x : x + C'(1);
  endfunction

  logic [C-1:0] pos_q, pos_d;
  logic [C-1:0] cur_start_q, cur_start_d;
  logic [C-1:0] cur_len_q, cur_len_d;
  logic [C-1:0] space_q, space_d;
  logic [C-1:0] word_begin_q, word_begin_d;
  logic [C-1:0] word_len_q, word_len_d;
  logic [C-1:0] widest_q, widest_d;

  logic         is_end, is_brk, is_sp;
  logic         word_pend;
  logic [C+1:0] sum3;
  logic         over3;
  logic [C-1:0] sat3;
  logic [C:0]   sum2;
  logic         over2;
  logic [C-1:0] sat2;
  logic [C-1:0] j_start, j_len, j_space;
  logic         j_emit, s_emit, sp_pend;
  logic [C-1:0] len2;
  logic         early, final_v;
  logic [C-1:0] f_start, f_len;
  logic [C-1:0] w_e, w_f;

  assign is_end = (char_i == CharEnd);
  assign is_brk = (char_i == CharLf) || (char_i == CharCr);
  assign is_sp  = (char_i == CharSpace);

  assign word_pend = (word_len_q != '0);
  assign sum3  = {2'b00, cur_len_q} + {2'b00, space_q} + {2'b00, word_len_q};
  assign over3 = CmpBits'(sum3) > CmpBits'(line_width_i);
  assign sat3  = (sum3 > {2'b00, CountMax}) ? CountMax : sum3[C-1:0];
  assign sum2  = {1'b0, cur_len_q} + {1'b0, space_q};
  assign over2 = CmpBits'(sum2) > CmpBits'(line_width_i);
  assign sat2  = (sum2 > {1'b0, CountMax}) ? CountMax : sum2[C-1:0];

  always_comb begin
    j_start = cur_start_q;
    j_len   = cur_len_q;
    j_space = space_q;
    j_emit  = 1'b0;
    if (word_pend) begin
      j_space = '0;
      if (cur_len_q == '0) begin
        j_start = word_begin_q;
        j_len   = word_len_q;
      end else if (over3) begin
        j_emit  = 1'b1;
        j_start = word_begin_q;
        j_len   = word_len_q;
      end else begin
        j_len = sat3;
      end
    end
  end

  assign sp_pend = !word_pend && (space_q != '0) && (cur_len_q != '0);
  assign s_emit  = is_brk && sp_pend && over2;

  always_comb begin
    len2 = j_len;
    if (sp_pend) begin
      len2 = over2 ? '0 : sat2;
    end
  end

  always_comb begin
    early   = 1'b0;
    final_v = 1'b0;
    f_start = j_start;
    f_len   = j_len;
    priority if (is_end) begin
      early   = j_emit;
      final_v = (j_len != '0);
    end else if (is_brk) begin
      early   = j_emit || s_emit;
      final_v = 1'b1;
      f_len   = len2;
      f_start = (len2 == '0) ? pos_q : j_start;
    end else if (is_sp) begin
      early = j_emit;
    end
  end

  assign w_e = (early && (cur_len_q > widest_q)) ? cur_len_q : widest_q;
  assign w_f = (f_len > w_e) ? f_len : w_e;

  always_comb begin
    pos_d        = sat_inc(pos_q);
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    space_d      = space_q;
    word_begin_d = word_begin_q;
    word_len_d   = word_len_q;
    widest_d     = widest_q;
    priority if (is_end) begin
      pos_d        = '0;
      cur_start_d  = '0;
      cur_len_d    = '0;
      space_d      = '0;
      word_begin_d = '0;
      word_len_d   = '0;
      widest_d     = '0;
    end else if (is_brk) begin
      cur_start_d = '0;
      cur_len_d   = '0;
      space_d     = '0;
      word_len_d  = '0;
      widest_d    = w_f;
    end else if (is_sp) begin
      cur_start_d = j_start;
      cur_len_d   = j_len;
      space_d     = sat_inc(j_space);
      word_len_d  = '0;
      widest_d    = w_e;
    end else begin
      word_begin_d = word_pend ? word_begin_q : pos_q;
      word_len_d   = sat_inc(word_len_q);
    end
  end

  assign fire_o = char_valid_i && (!(early || final_v) || ok_i);

  always_comb begin
    push_o              = '0;
    push_o.valid        = fire_o && (early || final_v);
    push_o.two          = early && final_v;
    push_o.first.start  = early ? clip(cur_start_q) : clip(f_start);
    push_o.first.length = early ? clip(cur_len_q) : clip(f_len);
    push_o.first.widest = early ? clip(w_e) : clip(w_f);
    push_o.first.last   = !(early && final_v);
    push_o.second.start  = clip(f_start);
    push_o.second.length = clip(f_len);
    push_o.second.widest = clip(w_f);
    push_o.second.last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      cur_start_q  <= '0;
      cur_len_q    <= '0;
      space_q      <= '0;
      word_begin_q <= '0;
      word_len_q   <= '0;
      widest_q     <= '0;
    end else if (fire_o) begin
      pos_q        <= pos_d;
      cur_start_q  <= cur_start_d;
      cur_len_q    <= cur_len_d;
      space_q      <= space_d;
      word_begin_q <= word_begin_d;
      word_len_q   <= word_len_d;
      widest_q     <= widest_d;
    end
  end

`ifndef SYNTH
  // The end of text returns every counter to zero.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && is_end) |=> (pos_q == '0) && (widest_q == '0) && (cur_len_q == '0))
    else $error("text state not cleared after end of text");

  // A word character always leaves a word pending.
  a_word_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && !is_end && !is_brk && !is_sp) |=> (word_len_q != '0))
    else $error("word length zero after a word character");

  // A break leaves an empty line with no pending spaces.
  a_break_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && is_brk) |=> (cur_len_q == '0) && (space_q == '0))
    else $error("line not emptied after a break");
`endif

endmodule

`default_nettype wire

// File: design/gwrap_outbuf.sv
// ----------------------------------------------------------------------------
// Greedy word wrap output buffer
// Result register with one pending slot for the second line of an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwrap_outbuf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gwrap_pkg::push_t                push_i,
  output logic                            ok_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gwrap_pkg::FieldBits-1:0] line_start_o,
  output logic [gwrap_pkg::FieldBits-1:0] line_length_o,
  output logic [gwrap_pkg::FieldBits-1:0] widest_line_o,
  output logic                            last_of_run_o
);
  import gwrap_pkg::*;

  logic out_valid_q;
  res_t out_q;
  logic pend_valid_q;
  res_t pend_q;
  logic take;

  assign take = out_valid_q && !out_stall_i;
  assign ok_o = !pend_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (push_i.valid) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= push_i.two;
      end else if (pend_valid_q && (!out_valid_q || take)) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      out_q <= push_i.first;
      if (push_i.two) begin
        pend_q <= push_i.second;
      end
    end else if (pend_valid_q && (!out_valid_q || take)) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_start_o  = out_q.start;
  assign line_length_o = out_q.length;
  assign widest_line_o = out_q.widest;
  assign last_of_run_o = out_q.last;

`ifndef SYNTH
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending line held without a presented line");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> ok_o)
    else $error("lines pushed while the buffer is full");

  a_two_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.valid && push_i.two) |=> (pend_valid_q && out_valid_q))
    else $error("second line of an item lost");
`endif

endmodule

`default_nettype wire
